>>> sv/semiplanar_yuv_to_rgb_pixel_top_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the semi-planar YUV to RGB pixel block
// Shared property wrappers so that every check uses the same clocking and
// reset qualification.
// ---------------------------------------------------------------------------
`ifndef SEMIPLANAR_YUV_TO_RGB_PIXEL_TOP_DEFINES_SVH
`define SEMIPLANAR_YUV_TO_RGB_PIXEL_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising edge, off during reset.
`define SYR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising edge, off during reset.
`define SYR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/syr_pkg.sv
// ---------------------------------------------------------------------------
// syr_pkg
// Types, widths and constants shared by the YUV to RGB pixel pipeline.
// ---------------------------------------------------------------------------
package syr_pkg;

  localparam int FRACTION_BITS_DEF = 20;

  localparam int LUMA_GAIN_W = 22;
  localparam int CHROMA_GAIN_W = 23;
  localparam int CFG_DATA_W = 23;
  localparam int CFG_INDEX_W = 3;

  // Luma weight times an 8-bit offset luma, and signed gain times signed chroma.
  localparam int LUMA_PROD_W = LUMA_GAIN_W + 8;
  localparam int CHROMA_PROD_W = CHROMA_GAIN_W + 8;
  // Three products plus the rounding half never exceed 2^32 in magnitude.
  localparam int SUM_W = 34;

  localparam logic [7:0] LUMA_OFFSET = 8'd16;
  localparam logic [7:0] CHROMA_MID = 8'h80;
  localparam logic [7:0] BYTE_MAX = 8'hFF;

  localparam logic [LUMA_GAIN_W-1:0] LUMA_GAIN_RST = 22'd1220542;
  localparam logic signed [CHROMA_GAIN_W-1:0] RED_V_GAIN_RST = 23'sd1673527;
  localparam logic signed [CHROMA_GAIN_W-1:0] GREEN_U_GAIN_RST = -23'sd409993;
  localparam logic signed [CHROMA_GAIN_W-1:0] GREEN_V_GAIN_RST = -23'sd852492;
  localparam logic signed [CHROMA_GAIN_W-1:0] BLUE_U_GAIN_RST = 23'sd2116026;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CHROMA_ORDER = 3'd0,
    REG_BLUE_FIRST   = 3'd1,
    REG_ALPHA_ON     = 3'd2,
    REG_LUMA_GAIN    = 3'd3,
    REG_RED_V_GAIN   = 3'd4,
    REG_GREEN_U_GAIN = 3'd5,
    REG_GREEN_V_GAIN = 3'd6,
    REG_BLUE_U_GAIN  = 3'd7
  } cfg_reg_e_t;

  // Load enables for the stages that live inside the per-pixel datapath.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
  } rgba_t;

endpackage

>>> sv/syr_pixel.sv
// ---------------------------------------------------------------------------
// syr_pixel
// Luma product, channel sums and round/clamp/format stages for one pixel.
// ---------------------------------------------------------------------------
module syr_pixel #(
  parameter int FRACTION_BITS = syr_pkg::FRACTION_BITS_DEF
) (
  input  logic                                       clk,
  input  syr_pkg::stage_en_t                         en,
  input  logic [7:0]                                 y_off,
  input  logic [syr_pkg::LUMA_GAIN_W-1:0]            luma_gain,
  input  logic signed [syr_pkg::CHROMA_PROD_W-1:0]   red_v_prod,
  input  logic signed [syr_pkg::CHROMA_PROD_W-1:0]   green_u_prod,
  input  logic signed [syr_pkg::CHROMA_PROD_W-1:0]   green_v_prod,
  input  logic signed [syr_pkg::CHROMA_PROD_W-1:0]   blue_u_prod,
  input  logic                                       blue_first,
  input  logic                                       alpha_on,
  output syr_pkg::rgba_t                             px
);

  localparam int SW = syr_pkg::SUM_W;
  localparam logic signed [SW-1:0] RND_HALF = SW'(1) <<< (FRACTION_BITS - 1);

  logic [syr_pkg::LUMA_PROD_W-1:0] yw_r, yw_nxt;
  logic signed [SW-1:0] sum_red_r, sum_grn_r, sum_blu_r;
  logic signed [SW-1:0] sum_red_nxt, sum_grn_nxt, sum_blu_nxt;
  logic signed [SW-1:0] yw_ext;
  logic [7:0] red_c, grn_c, blu_c;
  syr_pkg::rgba_t px_r, px_nxt;

  function automatic logic [7:0] clamp_byte(input logic signed [SW-1:0] s);
    logic signed [SW-1:0] q;
    logic [7:0] res;
    q = s >>> FRACTION_BITS;
    if (q[SW-1]) begin
      res = 8'd0;
    end else if (|q[SW-2:8]) begin
      res = syr_pkg::BYTE_MAX;
    end else begin
      res = q[7:0];
    end
    return res;
  endfunction

  assign yw_nxt = syr_pkg::LUMA_PROD_W'(luma_gain) * syr_pkg::LUMA_PROD_W'(y_off);
  assign yw_ext = signed'(SW'(yw_r));

  assign sum_red_nxt = yw_ext + SW'(red_v_prod) + RND_HALF;
  assign sum_grn_nxt = yw_ext + SW'(green_u_prod) + SW'(green_v_prod) + RND_HALF;
  assign sum_blu_nxt = yw_ext + SW'(blue_u_prod) + RND_HALF;

  always_comb begin
    red_c = clamp_byte(sum_red_r);
    grn_c = clamp_byte(sum_grn_r);
    blu_c = clamp_byte(sum_blu_r);
    px_nxt.byte0 = blue_first ? blu_c : red_c;
    px_nxt.byte1 = grn_c;
    px_nxt.byte2 = blue_first ? red_c : blu_c;
    px_nxt.byte3 = alpha_on ? syr_pkg::BYTE_MAX : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      yw_r <= yw_nxt;
    end
    if (en.s2) begin
      sum_red_r <= sum_red_nxt;
      sum_grn_r <= sum_grn_nxt;
      sum_blu_r <= sum_blu_nxt;
    end
    if (en.s3) begin
      px_r <= px_nxt;
    end
  end

  assign px = px_r;

endmodule

>>> sv/semiplanar_yuv_to_rgb_pixel_top.sv
// ---------------------------------------------------------------------------
// semiplanar_yuv_to_rgb_pixel_top
// Limited-range YUV to RGB conversion of one NV12/NV21 chroma site.
// ---------------------------------------------------------------------------
// Each input transfer carries the top-row and bottom-row luma bytes of one
// column pair and the interleaved chroma pair that both pixels share. Each
// output transfer carries both converted pixels as four bytes each.
// Both streams use valid/stall: a transfer happens on a rising edge where
// valid is high and stall is low.
// The datapath is a four-stage pipeline: input register, multipliers,
// channel sums with the rounding half, then shift, clamp and byte ordering
// into the output register. One item can enter every cycle while the
// output is not stalled, so sustained throughput is one item per clock.
// Each stage only waits when the stage after it is full and cannot move, so
// a stall on the output fills the bubbles first and only then backs up to
// in_stall; nothing is dropped or duplicated.
// Synchronous active-low reset empties the pipeline and loads the default
// BT.601 limited-range gains, NV12 chroma order, RGB order and alpha off.
// The configuration port always accepts (cfg_ready is tied high); it must
// only be written while the pipeline is empty.
// ---------------------------------------------------------------------------
`include "semiplanar_yuv_to_rgb_pixel_top_defines.svh"

module semiplanar_yuv_to_rgb_pixel_top #(
  parameter int FRACTION_BITS = syr_pkg::FRACTION_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        in_luma_top,
  input  logic [7:0]                        in_luma_bottom,
  input  logic [7:0]                        in_chroma_first,
  input  logic [7:0]                        in_chroma_second,

  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [7:0]                        out_top_byte0,
  output logic [7:0]                        out_top_byte1,
  output logic [7:0]                        out_top_byte2,
  output logic [7:0]                        out_top_byte3,
  output logic [7:0]                        out_bottom_byte0,
  output logic [7:0]                        out_bottom_byte1,
  output logic [7:0]                        out_bottom_byte2,
  output logic [7:0]                        out_bottom_byte3,

  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [syr_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [syr_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int PW = syr_pkg::CHROMA_PROD_W;

  // Configuration registers.
  logic                                     chroma_order_r;
  logic                                     blue_first_r;
  logic                                     alpha_on_r;
  logic [syr_pkg::LUMA_GAIN_W-1:0]          luma_gain_r;
  logic signed [syr_pkg::CHROMA_GAIN_W-1:0] red_v_gain_r;
  logic signed [syr_pkg::CHROMA_GAIN_W-1:0] green_u_gain_r;
  logic signed [syr_pkg::CHROMA_GAIN_W-1:0] green_v_gain_r;
  logic signed [syr_pkg::CHROMA_GAIN_W-1:0] blue_u_gain_r;

  // Pipeline occupancy and advance chain.
  logic v0_r, v1_r, v2_r, out_valid_r;
  logic adv0, adv1, adv2, adv3;
  syr_pkg::stage_en_t stage_en;

  // Stage 0: offset luma and centered chroma.
  logic [7:0]        y_top_r, y_bot_r, y_top_nxt, y_bot_nxt;
  logic signed [7:0] uc_r, vc_r, c_first, c_second;

  // Stage 1: chroma products shared by both pixels.
  logic signed [PW-1:0] red_v_prod_r, green_u_prod_r, green_v_prod_r, blue_u_prod_r;

  syr_pkg::rgba_t top_px, bot_px;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chroma_order_r <= 1'b0;
      blue_first_r   <= 1'b0;
      alpha_on_r     <= 1'b0;
      luma_gain_r    <= syr_pkg::LUMA_GAIN_RST;
      red_v_gain_r   <= syr_pkg::RED_V_GAIN_RST;
      green_u_gain_r <= syr_pkg::GREEN_U_GAIN_RST;
      green_v_gain_r <= syr_pkg::GREEN_V_GAIN_RST;
      blue_u_gain_r  <= syr_pkg::BLUE_U_GAIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (syr_pkg::cfg_reg_e_t'(cfg_index))
        syr_pkg::REG_CHROMA_ORDER: chroma_order_r <= cfg_data[0];
        syr_pkg::REG_BLUE_FIRST:   blue_first_r   <= cfg_data[0];
        syr_pkg::REG_ALPHA_ON:     alpha_on_r     <= cfg_data[0];
        syr_pkg::REG_LUMA_GAIN:    luma_gain_r    <= cfg_data[syr_pkg::LUMA_GAIN_W-1:0];
        syr_pkg::REG_RED_V_GAIN:   red_v_gain_r   <= signed'(cfg_data);
        syr_pkg::REG_GREEN_U_GAIN: green_u_gain_r <= signed'(cfg_data);
        syr_pkg::REG_GREEN_V_GAIN: green_v_gain_r <= signed'(cfg_data);
        syr_pkg::REG_BLUE_U_GAIN:  blue_u_gain_r  <= signed'(cfg_data);
        default: ;
      endcase
    end
  end

  // A stage may load when it is empty or when its contents move on this edge.
  assign adv3 = !out_valid_r || !out_stall;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;
  assign adv0 = !v0_r || adv1;
  assign in_stall = !adv0;

  assign stage_en.s1 = adv1;
  assign stage_en.s2 = adv2;
  assign stage_en.s3 = adv3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv0) begin
        v0_r <= in_valid;
      end
      if (adv1) begin
        v1_r <= v0_r;
      end
      if (adv2) begin
        v2_r <= v1_r;
      end
      if (adv3) begin
        out_valid_r <= v2_r;
      end
    end
  end

  // Luma below the black level counts as black; chroma is recentered by
  // flipping its top bit.
  assign y_top_nxt = (in_luma_top > syr_pkg::LUMA_OFFSET) ?
                     in_luma_top - syr_pkg::LUMA_OFFSET : 8'd0;
  assign y_bot_nxt = (in_luma_bottom > syr_pkg::LUMA_OFFSET) ?
                     in_luma_bottom - syr_pkg::LUMA_OFFSET : 8'd0;
  assign c_first  = signed'(in_chroma_first ^ syr_pkg::CHROMA_MID);
  assign c_second = signed'(in_chroma_second ^ syr_pkg::CHROMA_MID);

  always_ff @(posedge clk) begin
    if (adv0) begin
      y_top_r <= y_top_nxt;
      y_bot_r <= y_bot_nxt;
      uc_r    <= chroma_order_r ? c_second : c_first;
      vc_r    <= chroma_order_r ? c_first : c_second;
    end
    if (adv1) begin
      red_v_prod_r   <= PW'(red_v_gain_r) * PW'(vc_r);
      green_u_prod_r <= PW'(green_u_gain_r) * PW'(uc_r);
      green_v_prod_r <= PW'(green_v_gain_r) * PW'(vc_r);
      blue_u_prod_r  <= PW'(blue_u_gain_r) * PW'(uc_r);
    end
  end

  syr_pixel #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_top_px (
    .clk          (clk),
    .en           (stage_en),
    .y_off        (y_top_r),
    .luma_gain    (luma_gain_r),
    .red_v_prod   (red_v_prod_r),
    .green_u_prod (green_u_prod_r),
    .green_v_prod (green_v_prod_r),
    .blue_u_prod  (blue_u_prod_r),
    .blue_first   (blue_first_r),
    .alpha_on     (alpha_on_r),
    .px           (top_px)
  );

  syr_pixel #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_bot_px (
    .clk          (clk),
    .en           (stage_en),
    .y_off        (y_bot_r),
    .luma_gain    (luma_gain_r),
    .red_v_prod   (red_v_prod_r),
    .green_u_prod (green_u_prod_r),
    .green_v_prod (green_v_prod_r),
    .blue_u_prod  (blue_u_prod_r),
    .blue_first   (blue_first_r),
    .alpha_on     (alpha_on_r),
    .px           (bot_px)
  );

  assign out_valid        = out_valid_r;
  assign out_top_byte0    = top_px.byte0;
  assign out_top_byte1    = top_px.byte1;
  assign out_top_byte2    = top_px.byte2;
  assign out_top_byte3    = top_px.byte3;
  assign out_bottom_byte0 = bot_px.byte0;
  assign out_bottom_byte1 = bot_px.byte1;
  assign out_bottom_byte2 = bot_px.byte2;
  assign out_bottom_byte3 = bot_px.byte3;

  // The input only backs up once every stage holds an item and the output is stalled.
  `SYR_ASSERT_NOW(a_stall_only_when_full, in_stall,
    v0_r && v1_r && v2_r && out_valid_r && out_stall, "input stalled with a free stage")
  // An item leaving a stage always lands in the next one.
  `SYR_ASSERT_NEXT(a_s0_to_s1, v0_r && adv1, v1_r, "item lost between stage 0 and 1")
  `SYR_ASSERT_NEXT(a_s1_to_s2, v1_r && adv2, v2_r, "item lost between stage 1 and 2")
  `SYR_ASSERT_NEXT(a_s2_to_out, v2_r && adv3, out_valid_r, "item lost before the output")

endmodule
